// ----- rtl/fpbp_pkg.sv -----
// Shared constants, codes and the result record of the fit-policy placement block.
// No dependencies; the other files, fpbp_mem apart, refer to it by scoped names.
package fpbp_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_BLOCKS = 64;
  localparam int DEF_SIZE_WIDTH = 16;

  // Fixed field widths on the ports
  localparam int MODE_W     = 2;
  localparam int BLOCK_W    = 6;
  localparam int SIZE_W     = 16;
  localparam int POLICY_W   = 2;
  localparam int COUNT_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Input item modes
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PLACE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  // Placement policies
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;
  localparam logic [POLICY_W-1:0] POL_NEXT  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 2'd1;

  // Register reset values
  localparam logic [POLICY_W-1:0] FIT_POLICY_RESET    = POL_FIRST;
  localparam logic [COUNT_W-1:0]  BLOCKS_IN_USE_RESET = 7'd64;

  // One result transaction
  typedef struct packed {
    logic               granted;
    logic [BLOCK_W-1:0] chosen_block;
    logic [SIZE_W-1:0]  remaining_size;
  } res_t;

endpackage

// ----- rtl/fit_policy_block_placement.sv -----
// Fit-policy block placement: a table of memory blocks with load, read and
// place transactions; place picks a block by first, best, worst or next fit.
//
// Input channel: in_valid / in_stall with mode, block_index, size_value.
// Output channel: out_valid / out_stall with granted, chosen_block,
// remaining_size; one result transaction for every input transaction.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 fit_policy, 1 blocks_in_use); write only while the block is idle.
//
// One input transaction is handled at a time. A load or an unused mode goes
// straight to its result, a read waits for the registered table word, and a
// place scans the clamped blocks_in_use entries, one table entry per cycle
// through the single read port of the table memory, then commits its choice.
// A new input can be taken in the cycle after the previous result is registered.
//
// After reset the block runs a clearing pass over all MAX_BLOCKS table entries,
// holding in_stall high; configuration writes are taken throughout.
// When the receiver stalls, the result stays on the output register and the
// next input can still be accepted and worked on; its result waits until the
// output register frees.
// Depends on fpbp_pkg, fpbp_mem and fpbp_ctrl.
module fit_policy_block_placement #(
  parameter int MAX_BLOCKS = fpbp_pkg::DEF_MAX_BLOCKS,
  parameter int SIZE_WIDTH = fpbp_pkg::DEF_SIZE_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [fpbp_pkg::MODE_W-1:0]       mode,
  input  logic [fpbp_pkg::BLOCK_W-1:0]      block_index,
  input  logic [fpbp_pkg::SIZE_W-1:0]       size_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              granted,
  output logic [fpbp_pkg::BLOCK_W-1:0]      chosen_block,
  output logic [fpbp_pkg::SIZE_W-1:0]       remaining_size,
  input  logic                              cfg_we,
  input  logic [fpbp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fpbp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);

  logic [fpbp_pkg::POLICY_W-1:0] fit_policy;
  logic [fpbp_pkg::COUNT_W-1:0]  blocks_in_use;

  logic             res_valid;
  logic             res_take;
  fpbp_pkg::res_t   res;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [SIZE_WIDTH:0]   mem_wdata;
  logic [IDX_W-1:0]      mem_raddr;
  logic [SIZE_WIDTH:0]   mem_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy    <= fpbp_pkg::FIT_POLICY_RESET;
      blocks_in_use <= fpbp_pkg::BLOCKS_IN_USE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fpbp_pkg::REG_FIT_POLICY:    fit_policy    <= cfg_data[fpbp_pkg::POLICY_W-1:0];
        fpbp_pkg::REG_BLOCKS_IN_USE: blocks_in_use <= cfg_data[fpbp_pkg::COUNT_W-1:0];
        default: begin
          fit_policy <= fit_policy;
        end
      endcase
    end
  end

  // Output register: take a result when empty or draining this cycle
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      granted        <= res.granted;
      chosen_block   <= res.chosen_block;
      remaining_size <= res.remaining_size;
    end
  end

  fpbp_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .block_index   (block_index),
    .size_value    (size_value),
    .fit_policy    (fit_policy),
    .blocks_in_use (blocks_in_use),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res           (res),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  fpbp_mem #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (SIZE_WIDTH + 1)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ----- rtl/fpbp_mem.sv -----
// Block table memory: one write port, one read port, registered read data.
// No dependencies.
module fpbp_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 17
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/fpbp_ctrl.sv -----
// Sequencer of the placement block: clearing pass, load/read/place transactions,
// policy scan over the block table memory and the next-fit start pointer.
// Depends on fpbp_pkg.
module fpbp_ctrl #(
  parameter int MAX_BLOCKS = fpbp_pkg::DEF_MAX_BLOCKS,
  parameter int SIZE_WIDTH = fpbp_pkg::DEF_SIZE_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [fpbp_pkg::MODE_W-1:0]       mode,
  input  logic [fpbp_pkg::BLOCK_W-1:0]      block_index,
  input  logic [fpbp_pkg::SIZE_W-1:0]       size_value,
  input  logic [fpbp_pkg::POLICY_W-1:0]     fit_policy,
  input  logic [fpbp_pkg::COUNT_W-1:0]      blocks_in_use,
  output logic                              res_valid,
  input  logic                              res_take,
  output fpbp_pkg::res_t                    res,
  output logic                              mem_we,
  output logic [$clog2(MAX_BLOCKS)-1:0]     mem_waddr,
  output logic [SIZE_WIDTH:0]               mem_wdata,
  output logic [$clog2(MAX_BLOCKS)-1:0]     mem_raddr,
  input  logic [SIZE_WIDTH:0]               mem_rdata
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_RDWAIT = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]                      state;
  logic [IDX_W-1:0]                clr_addr;
  logic [IDX_W-1:0]                scan_addr;
  logic [CNT_W-1:0]                scan_cnt;
  logic                            rd_pend;
  logic [IDX_W-1:0]                rd_addr;
  logic                            found;
  logic [SIZE_WIDTH-1:0]           best_left;
  logic [IDX_W-1:0]                best_pos;
  logic [SIZE_WIDTH-1:0]           req;
  logic [IDX_W-1:0]                next_start;
  logic [fpbp_pkg::BLOCK_W-1:0]    hold_idx;
  logic                            hold_ok;
  fpbp_pkg::res_t                  res_q;

  logic [CNT_W-1:0]      n_eff;
  logic [IDX_W-1:0]      start;
  logic [SIZE_WIDTH-1:0] in_size;
  logic                  idx_ok;
  logic [IDX_W-1:0]      in_addr;
  logic                  rd_used;
  logic [SIZE_WIDTH-1:0] rd_rem;
  logic                  fit;
  logic [SIZE_WIDTH-1:0] left;
  logic                  take;
  logic                  scan_wrap;
  logic                  scan_done;
  logic [IDX_W-1:0]      after_pos;

  // Clamp the active block count to 1..MAX_BLOCKS
  always_comb begin
    if (blocks_in_use == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(blocks_in_use) > MAX_BLOCKS) begin
      n_eff = CNT_W'(MAX_BLOCKS);
    end else begin
      n_eff = CNT_W'(blocks_in_use);
    end
  end

  // Next fit restarts at block 0 when the pointer lies past the active range
  assign start = (fit_policy == fpbp_pkg::POL_NEXT && CNT_W'(next_start) < n_eff)
                 ? next_start : '0;

  assign in_size = SIZE_WIDTH'(size_value);
  assign idx_ok  = 32'(block_index) < MAX_BLOCKS;
  assign in_addr = IDX_W'(block_index);

  // Evaluate the word that the memory returns during a scan
  assign rd_used = mem_rdata[SIZE_WIDTH];
  assign rd_rem  = mem_rdata[SIZE_WIDTH-1:0];
  assign fit     = !rd_used && (req <= rd_rem);
  assign left    = rd_rem - req;
  assign take    = rd_pend && fit &&
                   (!found ||
                    (fit_policy == fpbp_pkg::POL_BEST  && left < best_left) ||
                    (fit_policy == fpbp_pkg::POL_WORST && left > best_left));

  assign scan_wrap = (CNT_W'(scan_addr) + 1'b1) == n_eff;
  assign scan_done = (scan_cnt == n_eff) && !rd_pend;
  assign after_pos = ((CNT_W'(best_pos) + 1'b1) == n_eff) ? '0 : best_pos + 1'b1;

  // Steer the memory ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = in_addr;
    mem_wdata = {1'b0, in_size};
    mem_raddr = in_addr;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        mem_we = in_valid && (mode == fpbp_pkg::MODE_LOAD) && idx_ok;
      end
      ST_SCAN: begin
        mem_raddr = scan_addr;
      end
      ST_COMMIT: begin
        mem_we    = found;
        mem_waddr = best_pos;
        mem_wdata = {1'b1, best_left};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      next_start <= '0;
      rd_pend    <= 1'b0;
      found      <= 1'b0;
      scan_cnt   <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if ((CNT_W'(clr_addr) + 1'b1) == CNT_W'(MAX_BLOCKS)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            req      <= in_size;
            hold_idx <= block_index;
            hold_ok  <= idx_ok;
            case (mode)
              fpbp_pkg::MODE_LOAD: begin
                res_q.granted        <= 1'b0;
                res_q.chosen_block   <= block_index;
                res_q.remaining_size <= idx_ok ? fpbp_pkg::SIZE_W'(in_size) : '0;
                state                <= ST_FINISH;
              end
              fpbp_pkg::MODE_PLACE: begin
                scan_addr <= start;
                scan_cnt  <= '0;
                rd_pend   <= 1'b0;
                found     <= 1'b0;
                state     <= ST_SCAN;
              end
              fpbp_pkg::MODE_READ: begin
                state <= ST_RDWAIT;
              end
              default: begin
                res_q <= '0;
                state <= ST_FINISH;
              end
            endcase
          end
        end
        ST_SCAN: begin
          // Issue one read a cycle, judge the word issued the cycle before
          rd_pend <= (scan_cnt != n_eff);
          rd_addr <= scan_addr;
          if (scan_cnt != n_eff) begin
            scan_cnt  <= scan_cnt + 1'b1;
            scan_addr <= scan_wrap ? '0 : scan_addr + 1'b1;
          end
          if (take) begin
            found     <= 1'b1;
            best_left <= left;
            best_pos  <= rd_addr;
          end
          if (scan_done) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (found) begin
            res_q.granted        <= 1'b1;
            res_q.chosen_block   <= fpbp_pkg::BLOCK_W'(best_pos);
            res_q.remaining_size <= fpbp_pkg::SIZE_W'(best_left);
            if (fit_policy == fpbp_pkg::POL_NEXT) begin
              next_start <= after_pos;
            end
          end else begin
            res_q <= '0;
          end
          state <= ST_FINISH;
        end
        ST_RDWAIT: begin
          res_q.chosen_block <= hold_idx;
          if (hold_ok) begin
            res_q.granted        <= rd_used;
            res_q.remaining_size <= fpbp_pkg::SIZE_W'(rd_rem);
          end else begin
            res_q.granted        <= 1'b0;
            res_q.remaining_size <= '0;
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign res_valid = (state == ST_FINISH);
  assign res       = res_q;

endmodule

// ----- rtl/fpbp_check.sv -----
// Port-level checks of the placement block, attached to the top level by bind.
// Depends on fpbp_pkg and fit_policy_block_placement.
module fpbp_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         granted,
  input logic [fpbp_pkg::BLOCK_W-1:0] chosen_block,
  input logic [fpbp_pkg::SIZE_W-1:0]  remaining_size
);

  // Hold a stalled result transaction
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(granted) && $stable(chosen_block)
                               && $stable(remaining_size))
    else $error("stalled result changed");

  // Stall input while reset and the clearing pass run
  assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input taken during clearing pass");

  // Work on one transaction at a time
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

  // A new result only follows a busy cycle
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work");

endmodule

bind fit_policy_block_placement fpbp_check u_check (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .granted        (granted),
  .chosen_block   (chosen_block),
  .remaining_size (remaining_size)
);

// ----- bench/tb_fit_policy_block_placement.sv -----
`timescale 1ns / 1ps
// Self-checking bench for fit_policy_block_placement: a table script, then random
// transactions under several register settings, checked against a shadow predictor.
// Depends on fpbp_pkg and the block's RTL only.
module tb_fit_policy_block_placement;

  localparam int HALF_PERIOD    = 6;
  localparam int CLK_PERIOD     = 2 * HALF_PERIOD;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int TABLE_SIZE     = 64;
  localparam int PHASES         = 12;
  localparam int ITEMS_PER_PHASE = 85;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 80;
  localparam int SCRIPT_ROWS    = 25;

  // Codes the package leaves unnamed
  localparam logic [fpbp_pkg::MODE_W-1:0]    MODE_SPARE  = 2'd3;
  localparam logic [fpbp_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [fpbp_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam logic                           ROW_ITEM    = 1'b0;
  localparam logic                           ROW_REG     = 1'b1;

  typedef struct packed {
    logic                         kind;
    logic [1:0]                   op;
    logic [fpbp_pkg::BLOCK_W-1:0] idx;
    logic [fpbp_pkg::SIZE_W-1:0]  amount;
    logic                         typed;
    fpbp_pkg::res_t               want;
  } script_row_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [fpbp_pkg::MODE_W-1:0]     mode = '0;
  logic [fpbp_pkg::BLOCK_W-1:0]    block_index = '0;
  logic [fpbp_pkg::SIZE_W-1:0]     size_value = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic                            granted;
  logic [fpbp_pkg::BLOCK_W-1:0]    chosen_block;
  logic [fpbp_pkg::SIZE_W-1:0]     remaining_size;
  logic                            cfg_we = 1'b0;
  logic [fpbp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [fpbp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the block's table and registers
  logic [fpbp_pkg::SIZE_W-1:0]   shadow_left [TABLE_SIZE];
  bit                            shadow_taken [TABLE_SIZE];
  int                            shadow_origin = 0;
  logic [fpbp_pkg::POLICY_W-1:0] shadow_policy = fpbp_pkg::FIT_POLICY_RESET;
  logic [fpbp_pkg::COUNT_W-1:0]  shadow_count = fpbp_pkg::BLOCKS_IN_USE_RESET;

  fpbp_pkg::res_t outcomes_due [$];
  int   fail_count = 0;
  int   checked_count = 0;
  int   sent_count = 0;
  int   placed_count = 0;
  int   burst_left = 0;
  int   hold_asked = 0;
  int   hold_served = 0;
  int   hold_left = 0;
  int   rx_cycle = 0;
  int   stall_style = 0;

  script_row_t script [SCRIPT_ROWS];

  fit_policy_block_placement dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .block_index    (block_index),
    .size_value     (size_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .granted        (granted),
    .chosen_block   (chosen_block),
    .remaining_size (remaining_size),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Clamp the block count the way the placement scan sees it
  function automatic int live_blocks();
    int n;
    n = shadow_count;
    if (n < 1) n = 1;
    if (n > TABLE_SIZE) n = TABLE_SIZE;
    return n;
  endfunction

  function automatic bit block_fits(int j, logic [fpbp_pkg::SIZE_W-1:0] need);
    return !shadow_taken[j] && need <= shadow_left[j];
  endfunction

  // Pick a block under the current policy; -1 when nothing fits
  function automatic int pick_fit_block(logic [fpbp_pkg::SIZE_W-1:0] need);
    int n;
    int j;
    int k;
    int pos;
    logic [fpbp_pkg::SIZE_W-1:0] left;
    logic [fpbp_pkg::SIZE_W-1:0] best_left;
    bit take;
    n = live_blocks();
    pos = -1;
    best_left = '0;
    if (shadow_policy == fpbp_pkg::POL_FIRST) begin
      for (j = 0; j < n; j++)
        if (block_fits(j, need)) return j;
      return -1;
    end
    if (shadow_policy == fpbp_pkg::POL_NEXT) begin
      k = (shadow_origin < n) ? shadow_origin : 0;
      for (j = 0; j < n; j++) begin
        if (block_fits(k, need)) return k;
        k = (k + 1 == n) ? 0 : k + 1;
      end
      return -1;
    end
    // Best and worst fit: lowest block wins a tie
    for (j = 0; j < n; j++) begin
      if (block_fits(j, need)) begin
        left = shadow_left[j] - need;
        if (pos < 0) take = 1'b1;
        else if (shadow_policy == fpbp_pkg::POL_BEST) take = left < best_left;
        else take = left > best_left;
        if (take) begin
          best_left = left;
          pos = j;
        end
      end
    end
    return pos;
  endfunction

  // Advance the shadow table by one transaction and return its result
  function automatic fpbp_pkg::res_t table_outcome(logic [fpbp_pkg::MODE_W-1:0] op,
                                                   logic [fpbp_pkg::BLOCK_W-1:0] idx,
                                                   logic [fpbp_pkg::SIZE_W-1:0] amount);
    fpbp_pkg::res_t r;
    int pos;
    r = '0;
    case (op)
      fpbp_pkg::MODE_LOAD: begin
        shadow_left[idx] = amount;
        shadow_taken[idx] = 1'b0;
        r.chosen_block = idx;
        r.remaining_size = amount;
      end
      fpbp_pkg::MODE_PLACE: begin
        pos = pick_fit_block(amount);
        if (pos >= 0) begin
          shadow_left[pos] = shadow_left[pos] - amount;
          shadow_taken[pos] = 1'b1;
          if (shadow_policy == fpbp_pkg::POL_NEXT)
            shadow_origin = (pos + 1 == live_blocks()) ? 0 : pos + 1;
          r.granted = 1'b1;
          r.chosen_block = fpbp_pkg::BLOCK_W'(pos);
          r.remaining_size = shadow_left[pos];
          placed_count++;
        end
      end
      fpbp_pkg::MODE_READ: begin
        r.granted = shadow_taken[idx];
        r.chosen_block = idx;
        r.remaining_size = shadow_left[idx];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic script_row_t mk_row(logic kind, logic [1:0] op,
                                         logic [fpbp_pkg::BLOCK_W-1:0] idx,
                                         logic [fpbp_pkg::SIZE_W-1:0] amount, logic typed,
                                         logic g, logic [fpbp_pkg::BLOCK_W-1:0] blk,
                                         logic [fpbp_pkg::SIZE_W-1:0] rem);
    script_row_t s;
    s.kind = kind;
    s.op = op;
    s.idx = idx;
    s.amount = amount;
    s.typed = typed;
    s.want.granted = g;
    s.want.chosen_block = blk;
    s.want.remaining_size = rem;
    return s;
  endfunction

  // Offer one transaction in bursts with random gaps; hold it until taken
  task automatic offer_item(logic [fpbp_pkg::MODE_W-1:0] op,
                            logic [fpbp_pkg::BLOCK_W-1:0] idx,
                            logic [fpbp_pkg::SIZE_W-1:0] amount, logic typed,
                            fpbp_pkg::res_t want);
    int gap;
    fpbp_pkg::res_t exp;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    mode <= op;
    block_index <= idx;
    size_value <= amount;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp = table_outcome(op, idx, amount);
    if (typed) exp = want;
    outcomes_due.push_back(exp);
    sent_count++;
  endtask

  // Stop offering and let every expected result come out
  task automatic wait_drained();
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Caller drops cfg_we after the last write of a sequence
  task automatic write_reg(logic [fpbp_pkg::CFG_IDX_W-1:0] ri,
                           logic [fpbp_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= ri;
    cfg_data <= val;
    @(posedge clk);
    if (ri == fpbp_pkg::REG_FIT_POLICY) shadow_policy = val[fpbp_pkg::POLICY_W-1:0];
    else if (ri == fpbp_pkg::REG_BLOCKS_IN_USE) shadow_count = val[fpbp_pkg::COUNT_W-1:0];
  endtask

  // Receiver: check each accepted result, stall on a shifting pattern
  always @(posedge clk) begin
    fpbp_pkg::res_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (outcomes_due.size() == 0) begin
          fail_count++;
          $display("%0t: expected no result, got granted=%0b block=%0d size=%0d", $time,
                   granted, chosen_block, remaining_size);
        end else begin
          want = outcomes_due.pop_front();
          checked_count++;
          if (granted !== want.granted || chosen_block !== want.chosen_block ||
              remaining_size !== want.remaining_size) begin
            fail_count++;
            $display("%0t: expected granted=%0b block=%0d size=%0d,", $time,
                     want.granted, want.chosen_block, want.remaining_size,
                     " got granted=%0b block=%0d size=%0d",
                     granted, chosen_block, remaining_size);
          end
        end
      end
      rx_cycle++;
      if (hold_served != hold_asked) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (rx_cycle % 160 == 0) stall_style = $urandom_range(0, 2);
        case (stall_style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 35);
          default: out_stall <= ((rx_cycle % 11) < 4);
        endcase
      end
    end
  end

  // Stimulus: fill, table script, then random phases
  initial begin
    int i;
    int ph;
    int r;
    int k;
    logic [fpbp_pkg::MODE_W-1:0] op;
    logic [fpbp_pkg::BLOCK_W-1:0] idx;
    logic [fpbp_pkg::SIZE_W-1:0] amount;
    logic [fpbp_pkg::POLICY_W-1:0] pol;
    logic [fpbp_pkg::COUNT_W-1:0] cnt;

    for (i = 0; i < TABLE_SIZE; i++) begin
      shadow_left[i] = '0;
      shadow_taken[i] = 1'b0;
    end

    // Extremes and reset values are typed in; the rest go to the predictor
    script[0]  = mk_row(ROW_ITEM, fpbp_pkg::MODE_LOAD, 6'd63, 16'hFFFF, 1'b1,
                        1'b0, 6'd63, 16'hFFFF);
    script[1]  = mk_row(ROW_ITEM, fpbp_pkg::MODE_LOAD, 6'd0, 16'h0000, 1'b1,
                        1'b0, 6'd0, 16'h0000);
    script[2]  = mk_row(ROW_ITEM, fpbp_pkg::MODE_READ, 6'd63, 16'h1234, 1'b1,
                        1'b0, 6'd63, 16'hFFFF);
    script[3]  = mk_row(ROW_ITEM, MODE_SPARE, 6'd21, 16'hABCD, 1'b1,
                        1'b0, 6'd0, 16'h0000);
    script[4]  = mk_row(ROW_ITEM, fpbp_pkg::MODE_PLACE, 6'd42, 16'hFFFF, 1'b1,
                        1'b1, 6'd63, 16'h0000);
    script[5]  = mk_row(ROW_ITEM, fpbp_pkg::MODE_PLACE, 6'd0, 16'hFFFF, 1'b1,
                        1'b0, 6'd0, 16'h0000);
    script[6]  = mk_row(ROW_ITEM, fpbp_pkg::MODE_READ, 6'd63, 16'h0000, 1'b1,
                        1'b1, 6'd63, 16'h0000);
    script[7]  = mk_row(ROW_ITEM, fpbp_pkg::MODE_PLACE, 6'd0, 16'h0000, 1'b1,
                        1'b1, 6'd0, 16'h0000);
    script[8]  = mk_row(ROW_ITEM, fpbp_pkg::MODE_PLACE, 6'd0, 16'd500, 1'b0,
                        1'b0, 6'd0, 16'h0);
    script[9]  = mk_row(ROW_REG, fpbp_pkg::REG_FIT_POLICY, 6'd0, 16'(fpbp_pkg::POL_BEST), 1'b0,
                        1'b0, 6'd0, 16'h0);
    script[10] = mk_row(ROW_ITEM, fpbp_pkg::MODE_PLACE, 6'd0, 16'd100, 1'b0,
                        1'b0, 6'd0, 16'h0);
    script[11] = mk_row(ROW_REG, fpbp_pkg::REG_FIT_POLICY, 6'd0, 16'(fpbp_pkg::POL_WORST), 1'b0,
                        1'b0, 6'd0, 16'h0);
    script[12] = mk_row(ROW_ITEM, fpbp_pkg::MODE_PLACE, 6'd0, 16'd100, 1'b0,
                        1'b0, 6'd0, 16'h0);
    script[13] = mk_row(ROW_REG, fpbp_pkg::REG_FIT_POLICY, 6'd0, 16'(fpbp_pkg::POL_NEXT), 1'b0,
                        1'b0, 6'd0, 16'h0);
    script[14] = mk_row(ROW_ITEM, fpbp_pkg::MODE_PLACE, 6'd0, 16'd100, 1'b0,
                        1'b0, 6'd0, 16'h0);
    script[15] = mk_row(ROW_ITEM, fpbp_pkg::MODE_PLACE, 6'd0, 16'd100, 1'b0,
                        1'b0, 6'd0, 16'h0);
    script[16] = mk_row(ROW_REG, fpbp_pkg::REG_BLOCKS_IN_USE, 6'd0, 16'd0, 1'b0,
                        1'b0, 6'd0, 16'h0);
    script[17] = mk_row(ROW_ITEM, fpbp_pkg::MODE_PLACE, 6'd0, 16'd0, 1'b0,
                        1'b0, 6'd0, 16'h0);
    script[18] = mk_row(ROW_ITEM, fpbp_pkg::MODE_LOAD, 6'd0, 16'd5, 1'b0,
                        1'b0, 6'd0, 16'h0);
    script[19] = mk_row(ROW_ITEM, fpbp_pkg::MODE_PLACE, 6'd0, 16'd5, 1'b0,
                        1'b0, 6'd0, 16'h0);
    script[20] = mk_row(ROW_REG, fpbp_pkg::REG_BLOCKS_IN_USE, 6'd0, 16'd127, 1'b0,
                        1'b0, 6'd0, 16'h0);
    script[21] = mk_row(ROW_ITEM, fpbp_pkg::MODE_PLACE, 6'd0, 16'd1, 1'b0,
                        1'b0, 6'd0, 16'h0);
    script[22] = mk_row(ROW_ITEM, fpbp_pkg::MODE_READ, 6'd0, 16'd0, 1'b0,
                        1'b0, 6'd0, 16'h0);
    script[23] = mk_row(ROW_ITEM, fpbp_pkg::MODE_READ, 6'd1, 16'd0, 1'b0,
                        1'b0, 6'd0, 16'h0);
    script[24] = mk_row(ROW_ITEM, fpbp_pkg::MODE_LOAD, 6'd42, 16'h8000, 1'b0,
                        1'b0, 6'd0, 16'h0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Load every block first so no scan or read touches an unwritten entry
    for (i = 0; i < TABLE_SIZE; i++)
      offer_item(fpbp_pkg::MODE_LOAD, fpbp_pkg::BLOCK_W'(i),
                 fpbp_pkg::SIZE_W'((((i * 7) % 16) + 1) * 64), 1'b0, '0);

    // Walk the script; register rows wait for the block to go idle
    for (i = 0; i < SCRIPT_ROWS; i++) begin
      if (script[i].kind == ROW_REG) begin
        in_valid <= 1'b0;
        wait_drained();
        write_reg(script[i].op, script[i].amount[fpbp_pkg::CFG_DATA_W-1:0]);
        cfg_we <= 1'b0;
      end else begin
        offer_item(script[i].op, script[i].idx, script[i].amount, script[i].typed,
                   script[i].want);
      end
    end

    // Random phases, each under its own register setting
    for (ph = 0; ph < PHASES; ph++) begin
      in_valid <= 1'b0;
      wait_drained();
      case (ph)
        0:  begin pol = fpbp_pkg::POL_FIRST; cnt = 7'd64;  end
        1:  begin pol = fpbp_pkg::POL_BEST;  cnt = 7'd64;  end
        2:  begin pol = fpbp_pkg::POL_WORST; cnt = 7'd64;  end
        3:  begin pol = fpbp_pkg::POL_NEXT;  cnt = 7'd64;  end
        4:  begin pol = fpbp_pkg::POL_NEXT;  cnt = 7'd5;   end
        5:  begin pol = fpbp_pkg::POL_BEST;  cnt = 7'd1;   end
        6:  begin pol = fpbp_pkg::POL_FIRST; cnt = 7'd0;   end
        7:  begin pol = fpbp_pkg::POL_WORST; cnt = 7'd127; end
        8:  begin pol = fpbp_pkg::POL_NEXT;  cnt = 7'd65;  end
        9:  begin pol = fpbp_pkg::POL_NEXT;  cnt = 7'd17;  end
        10: begin pol = fpbp_pkg::POL_FIRST; cnt = 7'd33;  end
        default: begin
          pol = fpbp_pkg::POLICY_W'($urandom_range(0, 3));
          cnt = fpbp_pkg::COUNT_W'($urandom_range(2, 64));
        end
      endcase
      // Upper policy bits carry junk; the spare indexes must be ignored
      write_reg(fpbp_pkg::REG_FIT_POLICY, {5'($urandom), pol});
      write_reg(fpbp_pkg::REG_BLOCKS_IN_USE, cnt);
      write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_3 : REG_SPARE_2, 7'($urandom));
      cfg_we <= 1'b0;
      if (ph == 2 || ph == 8) hold_asked <= hold_asked + 1;

      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 9);
        idx = fpbp_pkg::BLOCK_W'($urandom);
        if (r < 33) begin
          op = fpbp_pkg::MODE_LOAD;
          if ($urandom_range(0, 1) != 0)
            idx = fpbp_pkg::BLOCK_W'($urandom_range(0, live_blocks() - 1));
          if (k == 0) amount = '0;
          else if (k == 1) amount = '1;
          else if (k < 5) amount = fpbp_pkg::SIZE_W'(64 << $urandom_range(0, 3));
          else amount = fpbp_pkg::SIZE_W'($urandom);
        end else if (r < 75) begin
          op = fpbp_pkg::MODE_PLACE;
          if (k == 0) amount = '0;
          else if (k == 1) amount = '1;
          else if (k < 6)
            amount = shadow_left[$urandom_range(0, live_blocks() - 1)] >> $urandom_range(0, 2);
          else if (k < 8) amount = fpbp_pkg::SIZE_W'($urandom_range(0, 300));
          else amount = fpbp_pkg::SIZE_W'($urandom);
        end else if (r < 95) begin
          op = fpbp_pkg::MODE_READ;
          amount = fpbp_pkg::SIZE_W'($urandom);
        end else begin
          op = MODE_SPARE;
          amount = fpbp_pkg::SIZE_W'($urandom);
        end
        offer_item(op, idx, amount, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d transactions over %0d random register phases and all four policies;",
             sent_count, PHASES);
    $display("%0d results checked, %0d placements granted, with long output hold-offs.",
             checked_count, placed_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("%0t: timeout with %0d results outstanding", $time, outcomes_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
